// ----- hw/rtl/dnsle_pkg.sv -----
// ----------------------------------------------------------------------------
// dnsle_pkg: shared definitions of the name label encoder
// character codes, default label limit and the flush command flags
// ----------------------------------------------------------------------------
package dnsle_pkg;

  localparam int unsigned LABEL_MAX_DEF = 63;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] END_CHAR = 8'h00;

  // flags of one flush command handed from the front to the back
  typedef struct packed {
    logic bank;    // label buffer bank that holds the characters
    logic is_end;  // name terminator follows the label
    logic err;     // truncated label or dropped empty label
  } cmd_flags_t;

endpackage

// ----- hw/rtl/dnsle_label_ram.sv -----
// ----------------------------------------------------------------------------
// dnsle_label_ram: two-bank label character buffer
// one write port, two registered read ports sharing one enable
// ----------------------------------------------------------------------------
module dnsle_label_ram #(
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [7:0]        rdata_a_r,
  output logic [7:0]        rdata_b_r
);

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

endmodule

// ----- hw/rtl/dnsle_front.sv -----
// ----------------------------------------------------------------------------
// dnsle_front: character intake and classification
// stores label characters, turns dots and end bytes into flush commands
// ----------------------------------------------------------------------------
module dnsle_front #(
  parameter int unsigned LABEL_MAX = dnsle_pkg::LABEL_MAX_DEF,
  parameter int unsigned LEN_W     = $clog2(LABEL_MAX + 1),
  parameter int unsigned IDX_W     = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [7:0]            in_ch,
  input  logic                  q_full,
  // label buffer write port
  output logic                  ram_we,
  output logic [IDX_W:0]        ram_waddr,
  output logic [7:0]            ram_wdata,
  // command push
  output logic                  cmd_push,
  output dnsle_pkg::cmd_flags_t cmd_flags,
  output logic [LEN_W-1:0]      cmd_len
);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic             accept, is_dot, is_end, has_room;

  assign accept   = in_push && !q_full;
  assign is_dot   = (in_ch == dnsle_pkg::DOT_CHAR);
  assign is_end   = (in_ch == dnsle_pkg::END_CHAR);
  assign has_room = (len_r < LEN_W'(LABEL_MAX));

  assign ram_we    = accept && !is_dot && !is_end && has_room;
  assign ram_waddr = {bank_r, len_r[IDX_W-1:0]};
  assign ram_wdata = in_ch;

  assign cmd_push         = accept && (is_dot || is_end);
  assign cmd_flags.bank   = bank_r;
  assign cmd_flags.is_end = is_end;
  assign cmd_flags.err    = ovf_r || (is_dot && (len_r == '0));
  assign cmd_len          = len_r;

  always_comb begin
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (cmd_push) begin
      len_nxt  = '0;
      ovf_nxt  = 1'b0;
      bank_nxt = !bank_r;
    end else if (accept) begin
      if (has_room) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// ----- hw/rtl/dnsle_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// dnsle_cmd_queue: two-entry flush command queue
// one entry per label buffer bank, head stays until the back is done with it
// ----------------------------------------------------------------------------
module dnsle_cmd_queue #(
  parameter int unsigned LEN_W = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dnsle_pkg::cmd_flags_t push_flags,
  input  logic [LEN_W-1:0]      push_len,
  input  logic                  pop,
  output logic                  full,
  output logic                  head_valid,
  output dnsle_pkg::cmd_flags_t head_flags,
  output logic [LEN_W-1:0]      head_len
);

  dnsle_pkg::cmd_flags_t flags_r [2];
  logic [LEN_W-1:0]      len_r [2];
  logic                  wptr_r, rptr_r;
  logic [1:0]            count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_flags = flags_r[rptr_r];
  assign head_len   = len_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      flags_r[wptr_r] <= push_flags;
      len_r[wptr_r]   <= push_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/dnsle_back.sv -----
// ----------------------------------------------------------------------------
// dnsle_back: wire byte sequencer
// walks a flush command up to two bytes a step via a read stage and output register
// ----------------------------------------------------------------------------
module dnsle_back #(
  parameter int unsigned LABEL_MAX = dnsle_pkg::LABEL_MAX_DEF,
  parameter int unsigned LEN_W     = $clog2(LABEL_MAX + 1),
  parameter int unsigned IDX_W     = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command head
  input  logic                  q_valid,
  input  dnsle_pkg::cmd_flags_t q_flags,
  input  logic [LEN_W-1:0]      q_len,
  output logic                  q_pop,
  // label buffer read port
  output logic                  ram_re,
  output logic [IDX_W:0]        ram_raddr_a,
  output logic [IDX_W:0]        ram_raddr_b,
  input  logic [7:0]            ram_rdata_a,
  input  logic [7:0]            ram_rdata_b,
  // result channel
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [7:0]            out_byte_a,
  output logic [7:0]            out_byte_b,
  output logic [1:0]            out_byte_count,
  output logic                  out_name_end,
  output logic                  out_last,
  output logic                  out_error
);

  localparam int unsigned J_W = $clog2(LABEL_MAX / 2 + 2);
  localparam int unsigned C_W = J_W + 1 + LEN_W;

  typedef enum logic [1:0] {
    RES_EMPTY,
    RES_LABEL,
    RES_TERM
  } res_kind_t;

  logic [J_W-1:0]   j_r, j_nxt;
  logic [J_W:0]     j2, j2m1;
  logic [LEN_W-1:0] half;
  logic             label_phase, two_bytes, at_half;
  res_kind_t        kind;
  logic             last, issue;

  // read stage
  logic             s1_v_r;
  res_kind_t        s1_kind_r;
  logic             s1_first_r, s1_two_r, s1_last_r, s1_err_r;
  logic [LEN_W-1:0] s1_len_r;
  logic             s1_adv;

  // output register
  logic             out_v_r;
  logic [7:0]       byte_a_r, byte_b_r;
  logic [1:0]       count_r;
  logic             name_end_r, last_r, err_r;

  assign j2          = {j_r, 1'b0};
  assign j2m1        = j2 - (J_W + 1)'(1);
  assign half        = q_len >> 1;
  assign label_phase = (q_len != '0) && (C_W'(j_r) <= C_W'(half));
  assign two_bytes   = (C_W'(j2) < C_W'(q_len));
  assign at_half     = (C_W'(j_r) == C_W'(half));

  always_comb begin
    if (q_len == '0) begin
      kind = q_flags.is_end ? RES_TERM : RES_EMPTY;
    end else if (label_phase) begin
      kind = RES_LABEL;
    end else begin
      kind = RES_TERM;
    end
    last = (kind != RES_LABEL) || (at_half && !q_flags.is_end);
  end

  assign s1_adv = s1_v_r && (!out_v_r || out_pop);
  assign issue  = q_valid && (!s1_v_r || s1_adv);
  assign q_pop  = issue && last;

  assign ram_re      = issue;
  assign ram_raddr_a = {q_flags.bank, j2m1[IDX_W-1:0]};
  assign ram_raddr_b = {q_flags.bank, j2[IDX_W-1:0]};

  always_comb begin
    j_nxt = j_r;
    if (issue) begin
      j_nxt = last ? '0 : j_r + J_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r  <= kind;
      s1_first_r <= (j_r == '0);
      s1_two_r   <= two_bytes;
      s1_last_r  <= last;
      s1_err_r   <= q_flags.err;
      s1_len_r   <= q_len;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      name_end_r <= (s1_kind_r == RES_TERM);
      last_r     <= s1_last_r;
      err_r      <= s1_err_r;
      unique case (s1_kind_r)
        RES_LABEL: begin
          byte_a_r <= s1_first_r ? 8'(s1_len_r) : ram_rdata_a;
          byte_b_r <= s1_two_r ? ram_rdata_b : 8'h00;
          count_r  <= s1_two_r ? 2'd2 : 2'd1;
        end
        RES_TERM: begin
          byte_a_r <= 8'h00;
          byte_b_r <= 8'h00;
          count_r  <= 2'd1;
        end
        default: begin
          byte_a_r <= 8'h00;
          byte_b_r <= 8'h00;
          count_r  <= 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r     <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      j_r <= j_nxt;
      if (issue) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_empty      = !out_v_r;
  assign out_byte_a     = byte_a_r;
  assign out_byte_b     = byte_b_r;
  assign out_byte_count = count_r;
  assign out_name_end   = name_end_r;
  assign out_last       = last_r;
  assign out_error      = err_r;

endmodule

// ----- hw/rtl/dns_name_label_encoder.sv -----
// ----------------------------------------------------------------------------
// dns_name_label_encoder: dotted host name to wire-format label encoder
// characters in, length-prefixed labels and a zero terminator out
// ----------------------------------------------------------------------------
// usage
//   input queue: drive in_ch with in_push; a character transfers on a clock
//   edge with in_push high and in_full low. a dot closes the current label,
//   a zero byte closes the name.
//   result queue: while out_empty is low the oldest result is on the out_
//   ports; raise out_pop to take it. each result carries up to two wire bytes.
//   throughput: one character per cycle while a label buffer bank is free;
//   one result per cycle from the sequencer unless stalled; a label of
//   length L makes ceil((L+1)/2) results, plus the terminator at a name's end.
//   the two buffer banks and the two-entry command queue set this: in_full
//   rises only when two closed labels are still waiting to drain.
//   path: the first result of a dot or end byte passes the command queue,
//   the read stage and the output register, once earlier results have drained.
//   stall: with out_pop low the output register holds; the read stage and
//   then the command queue fill, and the input keeps taking characters into
//   the free bank until that bank is closed too.
//   reset: a synchronous rst_n low empties both queues and clears the label
//   count; the buffer itself needs no clearing.
// ----------------------------------------------------------------------------
module dns_name_label_encoder #(
  parameter int unsigned LABEL_MAX = dnsle_pkg::LABEL_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input queue
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_ch,
  // result queue
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_byte_a,
  output logic [7:0] out_byte_b,
  output logic [1:0] out_byte_count,
  output logic       out_name_end,
  output logic       out_last,
  output logic       out_error
);

  // length counter and buffer index widths
  localparam int unsigned LEN_W = $clog2(LABEL_MAX + 1);
  localparam int unsigned IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  // front to queue
  logic                  q_full;
  logic                  cmd_push;
  dnsle_pkg::cmd_flags_t cmd_flags;
  logic [LEN_W-1:0]      cmd_len;

  // queue to back
  logic                  q_valid;
  logic                  q_pop;
  dnsle_pkg::cmd_flags_t head_flags;
  logic [LEN_W-1:0]      head_len;

  // label buffer ports, address is {bank, index}
  logic                  ram_we;
  logic [IDX_W:0]        ram_waddr;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  logic [IDX_W:0]        ram_raddr_a;
  logic [IDX_W:0]        ram_raddr_b;
  logic [7:0]            ram_rdata_a;
  logic [7:0]            ram_rdata_b;

  // one queue entry per bank, so a full queue means the write bank is busy
  assign in_full = q_full;

  dnsle_front #(
    .LABEL_MAX (LABEL_MAX),
    .LEN_W     (LEN_W),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .cmd_push  (cmd_push),
    .cmd_flags (cmd_flags),
    .cmd_len   (cmd_len)
  );

  dnsle_cmd_queue #(
    .LEN_W (LEN_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_flags (cmd_flags),
    .push_len   (cmd_len),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_flags (head_flags),
    .head_len   (head_len)
  );

  dnsle_label_ram #(
    .ADDR_W (IDX_W + 1)
  ) u_ram (
    .clk       (clk),
    .we        (ram_we),
    .waddr     (ram_waddr),
    .wdata     (ram_wdata),
    .re        (ram_re),
    .raddr_a   (ram_raddr_a),
    .raddr_b   (ram_raddr_b),
    .rdata_a_r (ram_rdata_a),
    .rdata_b_r (ram_rdata_b)
  );

  dnsle_back #(
    .LABEL_MAX (LABEL_MAX),
    .LEN_W     (LEN_W),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_flags        (head_flags),
    .q_len          (head_len),
    .q_pop          (q_pop),
    .ram_re         (ram_re),
    .ram_raddr_a    (ram_raddr_a),
    .ram_raddr_b    (ram_raddr_b),
    .ram_rdata_a    (ram_rdata_a),
    .ram_rdata_b    (ram_rdata_b),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_byte_a     (out_byte_a),
    .out_byte_b     (out_byte_b),
    .out_byte_count (out_byte_count),
    .out_name_end   (out_name_end),
    .out_last       (out_last),
    .out_error      (out_error)
  );

endmodule

// ----- hw/rtl/dnsle_checker.sv -----
// ----------------------------------------------------------------------------
// dnsle_checker: port-level checks of the name label encoder
// result field consistency, stall hold and reset state
// ----------------------------------------------------------------------------
module dnsle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_pop,
  input logic       out_empty,
  input logic [7:0] out_byte_a,
  input logic [7:0] out_byte_b,
  input logic [1:0] out_byte_count,
  input logic       out_name_end,
  input logic       out_last,
  input logic       out_error
);

  // reset leaves both queues empty
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a waiting result keeps its bytes, byte count and last flag while not taken
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_byte_a) && $stable(out_byte_b) &&
       $stable(out_byte_count) && $stable(out_last)))
    else $error("stalled result changed");

  // the terminator is a lone zero byte closing the transfer group
  a_terminator: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_name_end) |->
      (out_byte_count == 2'd1 && out_byte_a == 8'h00 && out_last))
    else $error("malformed terminator result");

  // unused second byte reads as zero
  a_byte_b_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_byte_count != 2'd2) |-> (out_byte_b == 8'h00))
    else $error("second byte set on short result");

  // an empty result only marks a dropped label
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_byte_count == 2'd0) |->
      (out_error && out_last && !out_name_end && out_byte_a == 8'h00))
    else $error("empty result without dropped label");

endmodule

bind dns_name_label_encoder dnsle_checker u_dnsle_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the name label encoder
// host name characters are fed from a pending queue through a clocked driver,
// a tracking model predicts the wire-format results, and a clocked monitor
// compares every result transfer field by field under random stalls
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LBL_MAX = dnsle_pkg::LABEL_MAX_DEF;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned FEED_TARGET = 110;

  // one predicted result, fields at port widths
  typedef struct {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [1:0] byte_count;
    logic       name_end;
    logic       last;
    logic       error;
  } wire_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_ch = 8'h00;
  logic       out_pop = 1'b0;
  logic       out_empty;
  logic [7:0] out_byte_a;
  logic [7:0] out_byte_b;
  logic [1:0] out_byte_count;
  logic       out_name_end;
  logic       out_last;
  logic       out_error;

  // characters still to be offered, and the results still owed by the block
  logic [7:0] char_feed[$];
  wire_res_t  wire_exp[$];

  int stim_total = 0;
  int inputs_taken = 0;
  int fail_count = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  // tracked state of the current label
  logic [7:0] lbl_chars[LBL_MAX];
  logic [6:0] lbl_len = '0;
  logic       lbl_ovf = 1'b0;

  dns_name_label_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ch          (in_ch),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_byte_a     (out_byte_a),
    .out_byte_b     (out_byte_b),
    .out_byte_count (out_byte_count),
    .out_name_end   (out_name_end),
    .out_last       (out_last),
    .out_error      (out_error)
  );

  // ---------------------------------------------------------------- clocking
  initial begin
    forever #2 clk = ~clk;
  end

  // single reset at the start
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------- label tracking
  // works out the results one accepted character causes and queues them
  task automatic encode_char(input logic [7:0] c);
    logic [7:0] wire_bytes[$];
    wire_res_t  batch[$];
    wire_res_t  r;
    logic       err;
    int         pos;
    // ordinary character: stored, or dropped once the label is full
    if (c != dnsle_pkg::DOT_CHAR && c != dnsle_pkg::END_CHAR) begin
      if (lbl_len < LBL_MAX) begin
        lbl_chars[lbl_len] = c;
        lbl_len = lbl_len + 1'b1;
      end else begin
        lbl_ovf = 1'b1;
      end
      return;
    end
    err = lbl_ovf;
    if (lbl_len != 0) begin
      // length byte then the characters, packed two per result
      wire_bytes.push_back(8'(lbl_len));
      for (pos = 0; pos < lbl_len; pos++) wire_bytes.push_back(lbl_chars[pos]);
      for (pos = 0; pos < wire_bytes.size(); pos += 2) begin
        r.byte_a = wire_bytes[pos];
        r.name_end = 1'b0;
        r.last = 1'b0;
        r.error = err;
        if (pos + 1 < wire_bytes.size()) begin
          r.byte_b = wire_bytes[pos + 1];
          r.byte_count = 2'd2;
        end else begin
          r.byte_b = 8'h00;
          r.byte_count = 2'd1;
        end
        batch.push_back(r);
      end
    end else if (c == dnsle_pkg::DOT_CHAR) begin
      // empty label before a dot is dropped, flagged by an empty result
      r = '{byte_a: 8'h00, byte_b: 8'h00, byte_count: 2'd0,
            name_end: 1'b0, last: 1'b0, error: 1'b1};
      batch.push_back(r);
    end
    if (c == dnsle_pkg::END_CHAR) begin
      // zero terminator always closes the name, as a result of its own
      r = '{byte_a: 8'h00, byte_b: 8'h00, byte_count: 2'd1,
            name_end: 1'b1, last: 1'b0, error: err};
      batch.push_back(r);
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) wire_exp.push_back(batch[i]);
    lbl_len = '0;
    lbl_ovf = 1'b0;
  endtask

  // --------------------------------------------------------------- stimulus
  task automatic add_label(input int n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(1, 255)); while (c == dnsle_pkg::DOT_CHAR);
      char_feed.push_back(c);
    end
  endtask

  initial begin : build_feed
    int pick;
    int nlab;
    bit broken;
    // directed: empty name
    char_feed.push_back(dnsle_pkg::END_CHAR);
    // lone dot, then leading dot
    char_feed.push_back(dnsle_pkg::DOT_CHAR);
    char_feed.push_back(dnsle_pkg::END_CHAR);
    char_feed.push_back(dnsle_pkg::DOT_CHAR);
    char_feed.push_back(8'h61);
    char_feed.push_back(dnsle_pkg::END_CHAR);
    // two dots in a row
    char_feed.push_back(8'h62);
    char_feed.push_back(dnsle_pkg::DOT_CHAR);
    char_feed.push_back(dnsle_pkg::DOT_CHAR);
    char_feed.push_back(8'h63);
    char_feed.push_back(dnsle_pkg::END_CHAR);
    // trailing dot gives a single terminator
    char_feed.push_back(8'h78);
    char_feed.push_back(dnsle_pkg::DOT_CHAR);
    char_feed.push_back(dnsle_pkg::END_CHAR);
    // character extremes and neighbours of the dot code
    char_feed.push_back(8'h01);
    char_feed.push_back(8'hFF);
    char_feed.push_back(dnsle_pkg::END_CHAR);
    char_feed.push_back(8'h2D);
    char_feed.push_back(8'h2F);
    char_feed.push_back(dnsle_pkg::DOT_CHAR);
    char_feed.push_back(8'h80);
    char_feed.push_back(8'h7F);
    char_feed.push_back(dnsle_pkg::END_CHAR);
    // label one over the limit fills the buffer and is cut, closed by a dot
    add_label(LBL_MAX + 1);
    char_feed.push_back(dnsle_pkg::DOT_CHAR);
    add_label(2);
    char_feed.push_back(dnsle_pkg::END_CHAR);
    // random names, mostly well formed, some broken, some raw noise
    while (char_feed.size() < FEED_TARGET) begin
      pick = $urandom_range(7);
      if (pick == 0) begin
        repeat ($urandom_range(1, 5)) char_feed.push_back(8'($urandom_range(255)));
        char_feed.push_back(dnsle_pkg::END_CHAR);
      end else begin
        broken = (pick == 1);
        nlab = $urandom_range(1, 4);
        if (broken && $urandom_range(1)) char_feed.push_back(dnsle_pkg::DOT_CHAR);
        for (int l = 0; l < nlab; l++) begin
          add_label(($urandom_range(15) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 8));
          if (l != nlab - 1) begin
            char_feed.push_back(dnsle_pkg::DOT_CHAR);
            if (broken && $urandom_range(2) == 0) char_feed.push_back(dnsle_pkg::DOT_CHAR);
          end
        end
        if (broken && $urandom_range(1)) char_feed.push_back(dnsle_pkg::DOT_CHAR);
        char_feed.push_back(dnsle_pkg::END_CHAR);
      end
    end
    stim_total = char_feed.size();
  end

  // run phase from the number of accepted characters: the first third has a
  // lazy receiver, the second a lazy sender, the last runs flat out
  function automatic int run_phase();
    if (inputs_taken * 3 < stim_total) return 0;
    if (inputs_taken * 3 < stim_total * 2) return 1;
    return 2;
  endfunction

  function automatic int idle_pct(input bit rx_side);
    case (run_phase())
      0:       return rx_side ? 72 : 13;
      1:       return rx_side ? 13 : 72;
      default: return 0;
    endcase
  endfunction

  // ----------------------------------------------------------------- driver
  // a character transfers at an edge with push high and full low; a pending
  // offer is held untouched until it transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_ch <= 8'h00;
    end else begin
      if (in_push && !in_full) begin
        encode_char(in_ch);
        inputs_taken <= inputs_taken + 1;
      end
      if (!in_push || !in_full) begin
        if (char_feed.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          in_push <= 1'b1;
          in_ch <= char_feed.pop_front();
        end else begin
          // idle cycle, junk on the data lines
          in_push <= 1'b0;
          in_ch <= 8'($urandom_range(255));
        end
      end
    end
  end

  // --------------------------------------------------------------- hold-off
  // one long hold-off as the flat-out phase starts, so the block backs up
  // and raises full while the driver keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (!stall_done && run_phase() == 2) begin
      stall_left <= HOLD_OFF_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    wire_res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (wire_exp.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = wire_exp.pop_front();
          if (out_byte_a !== want.byte_a) begin
            $error("byte_a mismatch: expected %0h, actual %0h", want.byte_a, out_byte_a);
            fail_count++;
          end
          if (out_byte_b !== want.byte_b) begin
            $error("byte_b mismatch: expected %0h, actual %0h", want.byte_b, out_byte_b);
            fail_count++;
          end
          if (out_byte_count !== want.byte_count) begin
            $error("byte_count mismatch: expected %0d, actual %0d",
                   want.byte_count, out_byte_count);
            fail_count++;
          end
          if (out_name_end !== want.name_end) begin
            $error("name_end mismatch: expected %0b, actual %0b",
                   want.name_end, out_name_end);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_last);
            fail_count++;
          end
          if (out_error !== want.error) begin
            $error("error mismatch: expected %0b, actual %0b", want.error, out_error);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  // ------------------------------------------------------------ end of run
  initial begin : end_of_run
    while (rst_n !== 1'b1) @(posedge clk);
    while (inputs_taken < stim_total) @(posedge clk);
    while (wire_exp.size() != 0) @(posedge clk);
    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #800000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
